// ===== sv/sedp_pkg.sv =====
// ----------------------------------------------------------------------------
// sedp_pkg
// Constants, item codes and helper functions for the stereo echo delay core.
// ----------------------------------------------------------------------------
package sedp_pkg;

    localparam int FIFO_DEPTH   = 2048;
    localparam int HEAD_WORDS   = 128;
    localparam int SAMPLE_SHIFT = 16;

    localparam int FRAME_W = 32;
    localparam int DELAY_W = 10;
    localparam int PTR_W   = $clog2(FIFO_DEPTH);

    localparam int HALF_DEPTH = FIFO_DEPTH / 2;
    localparam int DELAY_HI   = (HALF_DEPTH > HEAD_WORDS) ? HALF_DEPTH - HEAD_WORDS : 1;

    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(8);

    typedef enum logic [1:0] {
        KIND_STORE   = 2'd0,
        KIND_FETCH   = 2'd1,
        KIND_RESTART = 2'd2
    } t_kind;

    // two's complement magnitude, most negative gives 2^31
    function automatic logic [FRAME_W-1:0] mag32(input logic [FRAME_W-1:0] w);
        mag32 = w[FRAME_W-1] ? (~w + FRAME_W'(1)) : w;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] q;
        q = {1'b0, p} + (PTR_W+1)'(1);
        if (q == (PTR_W+1)'(FIFO_DEPTH)) begin
            ptr_advance = PTR_W'(HEAD_WORDS);
        end else if (q == (PTR_W+1)'(HALF_DEPTH)) begin
            ptr_advance = PTR_W'(HALF_DEPTH + HEAD_WORDS);
        end else begin
            ptr_advance = q[PTR_W-1:0];
        end
    endfunction

    // read pointer load value with the delay saturated into range
    function automatic logic [PTR_W-1:0] rd_ptr_load(input logic [DELAY_W-1:0] d);
        logic [PTR_W:0] ds;
        logic [PTR_W:0] r;
        ds = (PTR_W+1)'(d);
        if (ds < (PTR_W+1)'(1)) begin
            ds = (PTR_W+1)'(1);
        end
        if (ds > (PTR_W+1)'(DELAY_HI)) begin
            ds = (PTR_W+1)'(DELAY_HI);
        end
        r = (PTR_W+1)'(FIFO_DEPTH) - ds;
        rd_ptr_load = r[PTR_W-1:0];
    endfunction

endpackage

// ===== sv/stereo_echo_delay_with_peaks_core.sv =====
// ----------------------------------------------------------------------------
// stereo_echo_delay_with_peaks_core
// Echo delay line for packed stereo frames with running left/right peak meters.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle while o_stall is low; each produces one
// result through the registered read of the single-write-port delay store and
// then the output register. After reset the store is cleared one word a cycle,
// so no item is accepted until all 2048 words are clear (o_stall high); delay writes
// are taken throughout. A new delay value takes effect at the next restart.
module stereo_echo_delay_with_peaks_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sedp_pkg::DELAY_W-1:0] i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_kind,
    input  logic [sedp_pkg::FRAME_W-1:0] i_frame_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [sedp_pkg::FRAME_W-1:0] o_frame_out,
    output logic [sedp_pkg::FRAME_W-1:0] o_left_meter,
    output logic [sedp_pkg::FRAME_W-1:0] o_right_meter
);
    import sedp_pkg::*;

    logic [FRAME_W-1:0] r_mem [FIFO_DEPTH];

    logic               r_clearing;
    logic [PTR_W-1:0]   r_clr_addr;
    logic [DELAY_W-1:0] r_delay;
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FRAME_W-1:0] r_left_max, n_left_max;
    logic [FRAME_W-1:0] r_right_max, n_right_max;

    logic               r_s1_valid;
    logic               r_s1_fetch;
    logic [FRAME_W-1:0] r_mem_q;
    logic [FRAME_W-1:0] r_s1_left;
    logic [FRAME_W-1:0] r_s1_right;

    logic               r_o_valid;
    logic [FRAME_W-1:0] r_o_frame;
    logic [FRAME_W-1:0] r_o_left;
    logic [FRAME_W-1:0] r_o_right;

    logic               s1_move;
    logic               in_acc;
    logic [FRAME_W-1:0] mag_l, mag_r;

    assign s1_move = !r_o_valid || !i_stall;
    assign o_stall = r_clearing || (r_s1_valid && !s1_move);
    assign in_acc  = i_valid && !o_stall;

    assign mag_r = mag32(i_frame_in);
    assign mag_l = mag32({i_frame_in[FRAME_W-SAMPLE_SHIFT-1:0], SAMPLE_SHIFT'(0)});

    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_left_max  = r_left_max;
        n_right_max = r_right_max;
        case (i_kind)
            KIND_STORE: begin
                n_wr_ptr = ptr_advance(r_wr_ptr);
                if (mag_l > r_left_max) begin
                    n_left_max = mag_l;
                end
                if (mag_r > r_right_max) begin
                    n_right_max = mag_r;
                end
            end
            KIND_FETCH: begin
                n_rd_ptr = ptr_advance(r_rd_ptr);
            end
            KIND_RESTART: begin
                n_wr_ptr    = PTR_W'(HEAD_WORDS);
                n_rd_ptr    = rd_ptr_load(r_delay);
                n_left_max  = '0;
                n_right_max = '0;
            end
            default: begin
            end
        endcase
    end

    // delay store, single write port and registered read
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (in_acc && i_kind == KIND_STORE) begin
            r_mem[r_wr_ptr] <= i_frame_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem_q <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_delay     <= DELAY_RESET;
            r_wr_ptr    <= PTR_W'(HEAD_WORDS);
            r_rd_ptr    <= rd_ptr_load(DELAY_RESET);
            r_left_max  <= '0;
            r_right_max <= '0;
            r_s1_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + PTR_W'(1);
                if (r_clr_addr == PTR_W'(FIFO_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                r_delay <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_wr_ptr    <= n_wr_ptr;
                r_rd_ptr    <= n_rd_ptr;
                r_left_max  <= n_left_max;
                r_right_max <= n_right_max;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_fetch <= (i_kind == KIND_FETCH);
            r_s1_left  <= n_left_max;
            r_s1_right <= n_right_max;
        end
        if (s1_move && r_s1_valid) begin
            r_o_frame <= r_s1_fetch ? r_mem_q : '0;
            r_o_left  <= r_s1_left;
            r_o_right <= r_s1_right;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_frame_out   = r_o_frame;
    assign o_left_meter  = r_o_left;
    assign o_right_meter = r_o_right;

    a_no_item_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !in_acc)
        else $error("item accepted during store clear");

    a_restart_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_kind == KIND_RESTART |=>
            r_wr_ptr == PTR_W'(HEAD_WORDS) && r_left_max == '0 && r_right_max == '0)
        else $error("restart did not reload pointers and peaks");

    a_peaks_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_kind != KIND_RESTART |=>
            r_left_max >= $past(r_left_max) && r_right_max >= $past(r_right_max))
        else $error("peak fell without restart");

    a_wr_ptr_off_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clearing |-> r_wr_ptr >= PTR_W'(HEAD_WORDS) &&
            !(r_wr_ptr >= PTR_W'(HALF_DEPTH) && r_wr_ptr < PTR_W'(HALF_DEPTH + HEAD_WORDS)))
        else $error("write pointer inside header words");

    a_non_fetch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && r_s1_valid && !r_s1_fetch |=> o_frame_out == '0)
        else $error("non-fetch result carries a frame");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo echo delay core with peak meters.
// ----------------------------------------------------------------------------
// A directed table covers the sample extremes, the spare item code, delay
// saturation and restarts. Random phases follow, each with its own delay
// setting: one long store-heavy run that wraps the write pointer past the
// header of the upper half, then shorter store/fetch mixes with occasional
// restarts. Every accepted item runs through a local model of the delay line
// and peak meters, and each result is compared field by field. Both sides
// idle at random; the receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import sedp_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 40;
    localparam int IDLE_PCT     = 38;
    localparam int NUM_PHASES   = 6;
    localparam int LONG_ITEMS   = 1000;
    localparam int SHORT_ITEMS  = 82;
    localparam int HOLD_AT      = 300;
    localparam int QUIET_FROM   = 500;
    localparam int QUIET_TO     = 700;
    localparam int NUM_ROWS     = 23;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam bit ROW_ITEM = 1'b0;
    localparam bit ROW_CFG  = 1'b1;
    localparam bit TYPED    = 1'b1;
    localparam bit PREDICT  = 1'b0;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [FRAME_W-1:0] left;
        logic [FRAME_W-1:0] right;
    } t_echo_out;

    typedef struct packed {
        logic               is_cfg;
        logic [DELAY_W-1:0] delay;
        logic [1:0]         kind;
        logic [FRAME_W-1:0] frame;
        logic               typed;
        t_echo_out          want;
    } t_row;

    t_row echo_rows [0:NUM_ROWS-1] = '{
        '{ROW_ITEM, 10'd0, KIND_FETCH, 32'h0000_0000, TYPED, '{32'h0, 32'h0, 32'h0}},
        '{ROW_ITEM, 10'd0, KIND_STORE, 32'h8000_0000, TYPED,
          '{32'h0, 32'h0, 32'h8000_0000}},
        '{ROW_ITEM, 10'd0, KIND_STORE, 32'h0000_8000, TYPED,
          '{32'h0, 32'h8000_0000, 32'h8000_0000}},
        '{ROW_ITEM, 10'd0, KIND_UNUSED, 32'hFFFF_FFFF, TYPED,
          '{32'h0, 32'h8000_0000, 32'h8000_0000}},
        '{ROW_ITEM, 10'd0, KIND_RESTART, 32'h0000_0000, TYPED, '{32'h0, 32'h0, 32'h0}},
        '{ROW_ITEM, 10'd0, KIND_STORE, 32'hFFFF_FFFF, TYPED,
          '{32'h0, 32'h0001_0000, 32'h0000_0001}},
        '{ROW_ITEM, 10'd0, KIND_STORE, 32'h7FFF_FFFF, TYPED,
          '{32'h0, 32'h0001_0000, 32'h7FFF_FFFF}},
        '{ROW_ITEM, 10'd0, KIND_STORE, 32'h0000_7FFF, TYPED,
          '{32'h0, 32'h7FFF_0000, 32'h7FFF_FFFF}},
        '{ROW_ITEM, 10'd0, KIND_FETCH, 32'h0000_0000, PREDICT, '0},
        '{ROW_CFG, 10'd0, KIND_STORE, 32'h0000_0000, PREDICT, '0},
        '{ROW_ITEM, 10'd0, KIND_RESTART, 32'h0000_0000, TYPED, '{32'h0, 32'h0, 32'h0}},
        '{ROW_ITEM, 10'd0, KIND_FETCH, 32'h0000_0000, PREDICT, '0},
        '{ROW_ITEM, 10'd0, KIND_FETCH, 32'h0000_0000, PREDICT, '0},
        '{ROW_ITEM, 10'd0, KIND_STORE, 32'h1234_5678, PREDICT, '0},
        '{ROW_ITEM, 10'd0, KIND_FETCH, 32'h0000_0000, PREDICT, '0},
        '{ROW_CFG, 10'd1023, KIND_STORE, 32'h0000_0000, PREDICT, '0},
        '{ROW_ITEM, 10'd0, KIND_RESTART, 32'hFFFF_FFFF, TYPED, '{32'h0, 32'h0, 32'h0}},
        '{ROW_ITEM, 10'd0, KIND_FETCH, 32'h0000_0000, PREDICT, '0},
        '{ROW_ITEM, 10'd0, KIND_STORE, 32'hDEAD_BEEF, PREDICT, '0},
        '{ROW_CFG, 10'd897, KIND_STORE, 32'h0000_0000, PREDICT, '0},
        '{ROW_ITEM, 10'd0, KIND_RESTART, 32'h0000_0000, TYPED, '{32'h0, 32'h0, 32'h0}},
        '{ROW_ITEM, 10'd0, KIND_STORE, 32'h0000_FFFF, TYPED,
          '{32'h0, 32'h0001_0000, 32'h0000_FFFF}},
        '{ROW_ITEM, 10'd0, KIND_FETCH, 32'h0000_0000, PREDICT, '0}
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [DELAY_W-1:0] i_cfg_wdata = '0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic [1:0]         i_kind      = KIND_STORE;
    logic [FRAME_W-1:0] i_frame_in  = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    logic [FRAME_W-1:0] o_frame_out;
    logic [FRAME_W-1:0] o_left_meter;
    logic [FRAME_W-1:0] o_right_meter;

    logic quiet    = 1'b0;
    logic hold_req = 1'b0;
    int   errors   = 0;
    int   cycles   = 0;

    t_echo_out echo_due [$];

    // model of the delay line and meters
    logic [FRAME_W-1:0] echo_mem [0:FIFO_DEPTH-1];
    int unsigned        wr_at;
    int unsigned        rd_at;
    logic [FRAME_W-1:0] left_hold;
    logic [FRAME_W-1:0] right_hold;
    logic [DELAY_W-1:0] delay_set;

    stereo_echo_delay_with_peaks_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_frame_in    (i_frame_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_frame_out   (o_frame_out),
        .o_left_meter  (o_left_meter),
        .o_right_meter (o_right_meter)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [FRAME_W-1:0] abs_level(input logic [FRAME_W-1:0] w);
        return w[FRAME_W-1] ? (~w + 32'd1) : w;
    endfunction

    function automatic int unsigned next_slot(input int unsigned p);
        int unsigned q;
        q = p + 1;
        if (q == FIFO_DEPTH) begin
            q = HEAD_WORDS;
        end else if (q == FIFO_DEPTH / 2) begin
            q = FIFO_DEPTH / 2 + HEAD_WORDS;
        end
        return q;
    endfunction

    function automatic void rewind_pointers();
        int unsigned d;
        int unsigned top;
        top = (FIFO_DEPTH / 2 > HEAD_WORDS) ? FIFO_DEPTH / 2 - HEAD_WORDS : 1;
        d = delay_set;
        if (d < 1) begin
            d = 1;
        end
        if (d > top) begin
            d = top;
        end
        wr_at      = HEAD_WORDS;
        rd_at      = FIFO_DEPTH - d;
        left_hold  = '0;
        right_hold = '0;
    endfunction

    function automatic t_echo_out predict_echo(input logic [1:0] kind,
                                               input logic [FRAME_W-1:0] frame);
        t_echo_out          r;
        logic [FRAME_W-1:0] lvl;
        r.frame = '0;
        case (kind)
            KIND_STORE: begin
                echo_mem[wr_at % FIFO_DEPTH] = frame;
                lvl = abs_level(frame);
                if (lvl > right_hold) begin
                    right_hold = lvl;
                end
                lvl = abs_level(frame << SAMPLE_SHIFT);
                if (lvl > left_hold) begin
                    left_hold = lvl;
                end
                wr_at = next_slot(wr_at);
            end
            KIND_FETCH: begin
                r.frame = echo_mem[rd_at % FIFO_DEPTH];
                rd_at = next_slot(rd_at);
            end
            KIND_RESTART: begin
                rewind_pointers();
            end
            default: begin
            end
        endcase
        r.left  = left_hold;
        r.right = right_hold;
        return r;
    endfunction

    task automatic report(input string what, input logic [FRAME_W-1:0] got,
                          input logic [FRAME_W-1:0] want);
        if (errors < MAX_REPORTS) begin
            $display("mismatch %s at cycle %0d: got %h want %h", what, cycles, got, want);
        end
        errors++;
    endtask

    task automatic offer(input logic [1:0] kind, input logic [FRAME_W-1:0] frame,
                         input bit typed, input t_echo_out want);
        t_echo_out due;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_frame_in <= frame;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        due = predict_echo(kind, frame);
        echo_due.push_back(typed ? want : due);
    endtask

    task automatic write_delay(input logic [DELAY_W-1:0] d);
        i_valid <= 1'b0;
        while (echo_due.size() != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        delay_set = d;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_echo_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (echo_due.size() == 0) begin
                report("unexpected item", o_frame_out, '0);
            end else begin
                want = echo_due.pop_front();
                if (o_frame_out !== want.frame) begin
                    report("frame_out", o_frame_out, want.frame);
                end
                if (o_left_meter !== want.left) begin
                    report("left meter", o_left_meter, want.left);
                end
                if (o_right_meter !== want.right) begin
                    report("right meter", o_right_meter, want.right);
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        int                 r;
        int                 n;
        int                 k;
        int                 ph;
        logic [1:0]         kind;
        logic [FRAME_W-1:0] frame;
        logic [DELAY_W-1:0] d;
        t_echo_out          no_want;

        no_want = '0;
        for (k = 0; k < FIFO_DEPTH; k++) begin
            echo_mem[k] = '0;
        end
        delay_set = DELAY_RESET;
        rewind_pointers();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < NUM_ROWS; k++) begin
            if (echo_rows[k].is_cfg) begin
                write_delay(echo_rows[k].delay);
            end else begin
                offer(echo_rows[k].kind, echo_rows[k].frame, echo_rows[k].typed,
                      echo_rows[k].want);
            end
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: d = DELAY_W'(DELAY_HI);
                1: d = 10'd1;
                2: d = 10'd0;
                5: d = '1;
                default: d = DELAY_W'($urandom_range(DELAY_HI - 1, 2));
            endcase
            write_delay(d);
            offer(KIND_RESTART, $urandom, PREDICT, no_want);
            n = (ph == 0) ? LONG_ITEMS : SHORT_ITEMS;
            for (k = 0; k < n; k++) begin
                if (ph == 0) begin
                    quiet <= (k >= QUIET_FROM && k < QUIET_TO);
                    if (k == HOLD_AT) begin
                        hold_req <= 1'b1;
                    end
                end
                r = $urandom_range(99);
                if (ph == 0) begin
                    kind = (r < 95) ? KIND_STORE : (r < 99) ? KIND_FETCH : KIND_UNUSED;
                end else begin
                    kind = (r < 47) ? KIND_STORE : (r < 94) ? KIND_FETCH :
                           (r < 97) ? KIND_RESTART : KIND_UNUSED;
                end
                if ($urandom_range(15) == 0) begin
                    case ($urandom_range(4))
                        0: frame = 32'h8000_0000;
                        1: frame = 32'h0000_8000;
                        2: frame = 32'hFFFF_FFFF;
                        3: frame = 32'h7FFF_FFFF;
                        default: frame = '0;
                    endcase
                end else begin
                    frame = $urandom;
                end
                offer(kind, frame, PREDICT, no_want);
            end
        end

        i_valid <= 1'b0;
        while (echo_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
